// File: rtl/bhs_pkg.sv
// ----------------------------------------------------------------------------
// bhs_pkg
// Shared codes, widths and control structs of the bucketed hash set unit.
// ----------------------------------------------------------------------------
package bhs_pkg;

    localparam int KEY_W    = 31;
    localparam int FUNC_W   = 2;
    localparam int STATUS_W = 2;

    // operation codes
    localparam logic [FUNC_W-1:0] FUNC_FIND   = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_DELETE = 2'd2;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_ABSENT = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL   = 2'd2;

    // bucket memory command
    typedef struct packed {
        logic rd;
        logic wr;
    } bhs_mem_cmd_t;

    // outcome of one operation on the bucket that was read
    typedef struct packed {
        logic                wr;
        logic [STATUS_W-1:0] status;
    } bhs_verdict_t;

endpackage

// File: rtl/bhs_mod.sv
// ----------------------------------------------------------------------------
// bhs_mod
// Pipelined key modulo bucket count: reciprocal multiply, then one correction.
// ----------------------------------------------------------------------------
module bhs_mod #(
    parameter int NUM_BUCKETS = 10
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [bhs_pkg::KEY_W-1:0]  key,
    output logic                       done,
    output logic [((NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1)-1:0] bucket
);
    import bhs_pkg::*;

    localparam int BKT_W  = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
    // quotient estimate is at most one low, so the raw remainder stays below 2N
    localparam int REM_W  = $clog2(2 * NUM_BUCKETS);
    localparam int RCP_W  = 32;
    localparam int PROD_W = KEY_W + RCP_W;
    localparam logic [63:0] RECIP_FULL = 64'hFFFF_FFFF / 64'(NUM_BUCKETS);
    localparam logic [RCP_W-1:0] RECIP = RECIP_FULL[RCP_W-1:0];
    localparam logic [REM_W-1:0] NB    = REM_W'(NUM_BUCKETS);

    logic [PROD_W-1:0] prod_reg;
    logic [PROD_W-1:0] prod_next;
    logic [REM_W-1:0]  key1_reg;
    logic [REM_W-1:0]  key2_reg;
    logic [REM_W-1:0]  qn_reg;
    logic [REM_W-1:0]  qn_next;
    logic [2*REM_W-1:0] qn_full;
    logic [REM_W-1:0]  q_low;
    logic [REM_W-1:0]  rem_raw;
    logic [REM_W-1:0]  rem_fix;
    logic              v1_reg;
    logic              v2_reg;

    assign prod_next = PROD_W'(key) * PROD_W'(RECIP);

    // only the low bits of q*N matter, the remainder is known to be small
    assign q_low   = prod_reg[RCP_W +: REM_W];
    assign qn_full = q_low * NB;
    assign qn_next = qn_full[REM_W-1:0];

    assign rem_raw = key2_reg - qn_reg;
    assign rem_fix = (rem_raw >= NB) ? (rem_raw - NB) : rem_raw;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= start;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        key1_reg <= key[REM_W-1:0];
        key2_reg <= key1_reg;
        qn_reg   <= qn_next;
    end

    assign done   = v2_reg;
    assign bucket = rem_fix[BKT_W-1:0];

    property p_bucket_range;
        @(posedge clk) disable iff (!rst_n)
        done |-> (rem_fix < NB);
    endproperty
    a_bucket_range: assert property (p_bucket_range)
        else $error("bucket index out of range");

    property p_done_follows_start;
        @(posedge clk) disable iff (!rst_n)
        start |=> ##1 done;
    endproperty
    a_done_follows_start: assert property (p_done_follows_start)
        else $error("modulo result did not follow start");

    property p_no_overlap;
        @(posedge clk) disable iff (!rst_n)
        v1_reg |-> !start;
    endproperty
    a_no_overlap: assert property (p_no_overlap)
        else $error("new key started while modulo busy");

endmodule

// File: rtl/bhs_store.sv
// ----------------------------------------------------------------------------
// bhs_store
// Bucket memory: one row per bucket holding its slot keys and used mask.
// ----------------------------------------------------------------------------
module bhs_store #(
    parameter int NUM_BUCKETS  = 10,
    parameter int BUCKET_SLOTS = 8
) (
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  bhs_pkg::bhs_mem_cmd_t                       cmd,
    input  logic [((NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1)-1:0] addr,
    input  logic [BUCKET_SLOTS*bhs_pkg::KEY_W-1:0]      wr_keys,
    input  logic [BUCKET_SLOTS-1:0]                     wr_used,
    output logic [BUCKET_SLOTS*bhs_pkg::KEY_W-1:0]      rd_keys,
    output logic [BUCKET_SLOTS-1:0]                     rd_used
);
    import bhs_pkg::*;

    localparam int BKT_W = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
    localparam int KEYS_W = BUCKET_SLOTS * KEY_W;
    localparam int ROW_W  = KEYS_W + BUCKET_SLOTS;

    logic [ROW_W-1:0]       mem [NUM_BUCKETS];
    logic [ROW_W-1:0]       rd_row_reg;
    logic [BKT_W-1:0]       addr_reg;
    logic [NUM_BUCKETS-1:0] row_valid_reg;
    logic                   rd_valid_reg;

    // writes go back to the row of the last read
    always_ff @(posedge clk)
    begin
        if (cmd.wr)
        begin
            mem[addr_reg] <= {wr_used, wr_keys};
        end
        if (cmd.rd)
        begin
            rd_row_reg <= mem[addr];
            addr_reg   <= addr;
        end
    end

    // a row never written reads as an empty bucket
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_valid_reg <= '0;
            rd_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.wr)
            begin
                row_valid_reg[addr_reg] <= 1'b1;
            end
            if (cmd.rd)
            begin
                rd_valid_reg <= row_valid_reg[addr];
            end
        end
    end

    assign rd_keys = rd_row_reg[KEYS_W-1:0];
    assign rd_used = rd_row_reg[ROW_W-1:KEYS_W] & {BUCKET_SLOTS{rd_valid_reg}};

endmodule

// File: rtl/bhs_match.sv
// ----------------------------------------------------------------------------
// bhs_match
// Slot compare and update: decides status and the new row for one operation.
// ----------------------------------------------------------------------------
module bhs_match #(
    parameter int BUCKET_SLOTS = 8
) (
    input  logic [bhs_pkg::FUNC_W-1:0]             func,
    input  logic [bhs_pkg::KEY_W-1:0]              key,
    input  logic [BUCKET_SLOTS*bhs_pkg::KEY_W-1:0] rd_keys,
    input  logic [BUCKET_SLOTS-1:0]                rd_used,
    output bhs_pkg::bhs_verdict_t                  verdict,
    output logic [BUCKET_SLOTS*bhs_pkg::KEY_W-1:0] wr_keys,
    output logic [BUCKET_SLOTS-1:0]                wr_used
);
    import bhs_pkg::*;

    logic [BUCKET_SLOTS-1:0]       hit;
    logic [BUCKET_SLOTS-1:0]       free;
    logic [BUCKET_SLOTS-1:0]       first_free;
    logic [BUCKET_SLOTS*KEY_W-1:0] ins_keys;
    logic                          any_hit;
    logic                          full;

    always_comb
    begin
        for (int s = 0; s < BUCKET_SLOTS; s++)
        begin
            hit[s] = rd_used[s] && (rd_keys[s*KEY_W +: KEY_W] == key);
        end
    end

    // lowest free slot as a one-hot mask
    assign free       = ~rd_used;
    assign first_free = free & (~free + BUCKET_SLOTS'(1));
    assign any_hit    = |hit;
    assign full       = ~|free;

    always_comb
    begin
        for (int s = 0; s < BUCKET_SLOTS; s++)
        begin
            ins_keys[s*KEY_W +: KEY_W] = first_free[s] ? key : rd_keys[s*KEY_W +: KEY_W];
        end
    end

    always_comb
    begin
        verdict.wr     = 1'b0;
        verdict.status = ST_ABSENT;
        wr_keys        = rd_keys;
        wr_used        = rd_used;
        case (func)
            FUNC_FIND:
            begin
                verdict.status = any_hit ? ST_OK : ST_ABSENT;
            end
            FUNC_INSERT:
            begin
                if (any_hit)
                begin
                    verdict.status = ST_ABSENT;
                end
                else if (full)
                begin
                    verdict.status = ST_FULL;
                end
                else
                begin
                    verdict.status = ST_OK;
                    verdict.wr     = 1'b1;
                    wr_keys        = ins_keys;
                    wr_used        = rd_used | first_free;
                end
            end
            FUNC_DELETE:
            begin
                if (any_hit)
                begin
                    verdict.status = ST_OK;
                    verdict.wr     = 1'b1;
                    wr_used        = rd_used & ~hit;
                end
            end
            default:
            begin
                verdict.status = ST_ABSENT;
            end
        endcase
    end

endmodule

// File: rtl/bucketed_hash_set_unit.sv
// ----------------------------------------------------------------------------
// bucketed_hash_set_unit
// Set of 31-bit keys in buckets chosen by key modulo the bucket count.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one request per transaction: an operation (find, insert,
//   delete) and a key. m_axis returns one status per request, in order:
//   0 success or found, 1 absent or duplicate, 2 bucket full.
//   A request passes from acceptance to the next acceptance through the
//   reciprocal-multiply modulo pipeline (its last stage issues the
//   synchronous read of the bucket row), a state with the row in the read
//   register, a state that compares the slots and writes the row back once
//   the output register is free, and the idle state in which s_axis_tready
//   is high again. The status enters the output register when the request
//   resolves. Only one request is in flight, so the read and write-back of a
//   row never overlap with another access.
//   The status sits in an output register; the next request is taken while
//   it waits. If the receiver still holds off when the following status is
//   ready, the unit waits with that request and s_axis_tready stays low.
//   Reset empties the set at once (per-row valid bits) and clears all
//   handshake state; no clearing pass is needed.
// ----------------------------------------------------------------------------
module bucketed_hash_set_unit #(
    parameter int NUM_BUCKETS  = 10,
    parameter int BUCKET_SLOTS = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // func[1:0], key[32:2], zero pad [39:33]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata    // status[1:0], zero pad [7:2]
);
    import bhs_pkg::*;

    localparam int BKT_W  = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
    localparam int KEYS_W = BUCKET_SLOTS * KEY_W;

    localparam logic [1:0] S_IDLE    = 2'd0;
    localparam logic [1:0] S_DIV     = 2'd1;
    localparam logic [1:0] S_READ    = 2'd2;
    localparam logic [1:0] S_RESOLVE = 2'd3;

    logic [1:0]          state_reg;
    logic [1:0]          state_next;
    logic [FUNC_W-1:0]   func_reg;
    logic [KEY_W-1:0]    key_reg;
    logic                out_valid_reg;
    logic [STATUS_W-1:0] status_reg;

    logic                accept;
    logic                out_free;
    logic                finish;
    logic                mod_done;
    logic [BKT_W-1:0]    bucket;
    bhs_mem_cmd_t        mem_cmd;
    bhs_verdict_t        verdict;
    logic [KEYS_W-1:0]   rd_keys;
    logic [KEYS_W-1:0]   wr_keys;
    logic [BUCKET_SLOTS-1:0] rd_used;
    logic [BUCKET_SLOTS-1:0] wr_used;

    assign s_axis_tready = (state_reg == S_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign finish        = (state_reg == S_RESOLVE) && out_free;

    bhs_mod #(
        .NUM_BUCKETS (NUM_BUCKETS)
    ) u_mod (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (accept),
        .key    (s_axis_tdata[FUNC_W +: KEY_W]),
        .done   (mod_done),
        .bucket (bucket)
    );

    assign mem_cmd.rd = mod_done;
    assign mem_cmd.wr = finish && verdict.wr;

    bhs_store #(
        .NUM_BUCKETS  (NUM_BUCKETS),
        .BUCKET_SLOTS (BUCKET_SLOTS)
    ) u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (mem_cmd),
        .addr    (bucket),
        .wr_keys (wr_keys),
        .wr_used (wr_used),
        .rd_keys (rd_keys),
        .rd_used (rd_used)
    );

    bhs_match #(
        .BUCKET_SLOTS (BUCKET_SLOTS)
    ) u_match (
        .func    (func_reg),
        .key     (key_reg),
        .rd_keys (rd_keys),
        .rd_used (rd_used),
        .verdict (verdict),
        .wr_keys (wr_keys),
        .wr_used (wr_used)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (mod_done)
                begin
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                state_next = S_RESOLVE;
            end
            S_RESOLVE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            func_reg <= s_axis_tdata[FUNC_W-1:0];
            key_reg  <= s_axis_tdata[FUNC_W +: KEY_W];
        end
        if (finish)
        begin
            status_reg <= verdict.status;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {(8 - STATUS_W)'(0), status_reg};

    property p_write_only_resolve;
        @(posedge clk) disable iff (!rst_n)
        mem_cmd.wr |-> (state_reg == S_RESOLVE);
    endproperty
    a_write_only_resolve: assert property (p_write_only_resolve)
        else $error("bucket write outside resolve");

    property p_read_only_div;
        @(posedge clk) disable iff (!rst_n)
        mod_done |-> (state_reg == S_DIV);
    endproperty
    a_read_only_div: assert property (p_read_only_div)
        else $error("bucket read outside modulo wait");

    property p_finish_shows_result;
        @(posedge clk) disable iff (!rst_n)
        finish |=> (m_axis_tvalid && state_reg == S_IDLE);
    endproperty
    a_finish_shows_result: assert property (p_finish_shows_result)
        else $error("finished request did not reach output register");

    property p_accept_starts;
        @(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == S_DIV);
    endproperty
    a_accept_starts: assert property (p_accept_starts)
        else $error("accepted request did not start");

    property p_status_code;
        @(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (status_reg == ST_OK || status_reg == ST_ABSENT
                           || status_reg == ST_FULL);
    endproperty
    a_status_code: assert property (p_status_code)
        else $error("invalid status code");

endmodule

// File: sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the bucketed hash set unit.
// Requests go in as bursts with random gaps and statuses are taken under a
// changing stall pattern. A local copy of the bucket slots predicts each
// status, and the results are compared in order as they come out.
// ----------------------------------------------------------------------------
module tb;
    import bhs_pkg::*;

    localparam int NUM_BUCKETS  = 10;
    localparam int BUCKET_SLOTS = 8;
    localparam int TOTAL_SLOTS  = NUM_BUCKETS * BUCKET_SLOTS;
    localparam int RANDOM_REQS  = 500;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 8;

    // opcode the unit must ignore
    localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
    localparam logic [KEY_W-1:0]  KEY_MAX     = {KEY_W{1'b1}};

    typedef struct {
        logic [FUNC_W-1:0]   func;
        logic [KEY_W-1:0]    key;
        logic [STATUS_W-1:0] status;
    } status_expect_t;

    class hash_set_scoreboard;
        logic [KEY_W-1:0] slot_key [TOTAL_SLOTS];
        bit               slot_used[TOTAL_SLOTS];
        status_expect_t   status_q[$];
        int               failures;

        function new();
            for (int i = 0; i < TOTAL_SLOTS; i++)
            begin
                slot_key[i]  = '0;
                slot_used[i] = 1'b0;
            end
            failures = 0;
        endfunction

        function int pending();
            return status_q.size();
        endfunction

        // update the local set and queue the status this request must return
        function void note_request(logic [FUNC_W-1:0] func, logic [KEY_W-1:0] key);
            int unsigned    k;
            int             base;
            int             hit;
            int             free_slot;
            status_expect_t e;
            k = {1'b0, key};
            base = (k % NUM_BUCKETS) * BUCKET_SLOTS;
            hit = -1;
            free_slot = -1;
            for (int s = 0; s < BUCKET_SLOTS; s++)
            begin
                if (slot_used[base + s] && slot_key[base + s] == key && hit < 0)
                    hit = base + s;
                if (!slot_used[base + s] && free_slot < 0)
                    free_slot = base + s;
            end
            e.func   = func;
            e.key    = key;
            e.status = ST_ABSENT;
            case (func)
                FUNC_FIND:
                    if (hit >= 0)
                        e.status = ST_OK;
                FUNC_INSERT:
                    if (hit < 0)
                    begin
                        if (free_slot < 0)
                            e.status = ST_FULL;
                        else
                        begin
                            slot_used[free_slot] = 1'b1;
                            slot_key[free_slot]  = key;
                            e.status = ST_OK;
                        end
                    end
                FUNC_DELETE:
                    if (hit >= 0)
                    begin
                        slot_used[hit] = 1'b0;
                        e.status = ST_OK;
                    end
                default: ;
            endcase
            status_q.push_back(e);
        endfunction

        function void check_status(logic [STATUS_W-1:0] got);
            status_expect_t e;
            if (status_q.size() == 0)
            begin
                failures++;
                if (failures <= 10)
                    $display("unexpected status transaction: got %0d", got);
                return;
            end
            e = status_q.pop_front();
            if (got !== e.status)
            begin
                failures++;
                if (failures <= 10)
                    $display("status mismatch: func %0d key %0d expected %0d got %0d",
                             e.func, e.key, e.status, got);
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;

    hash_set_scoreboard sb = new();

    int unsigned cycles = 0;
    int          burst_left = 1;
    int          rx_mode = 0;
    int          rx_count = 0;

    bucketed_hash_set_unit #(
        .NUM_BUCKETS  (NUM_BUCKETS),
        .BUCKET_SLOTS (BUCKET_SLOTS)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("tb NOT OK");
            $finish;
        end
    end

    // receiver: the stall mode is redrawn whenever its countdown runs out
    always @(posedge clk)
    begin
        if (rx_count == 0)
        begin
            rx_mode  <= $urandom_range(0, 3);
            rx_count <= $urandom_range(20, 80);
        end
        else
            rx_count <= rx_count - 1;
        case (rx_mode)
            0: m_axis_tready <= 1'b1;
            1: m_axis_tready <= 1'($urandom_range(0, 1));
            2: m_axis_tready <= ($urandom_range(0, 7) == 0);
            default: m_axis_tready <= (cycles[3:0] < 4'd3);
        endcase
    end

    // outputs are stable between edges, so sample the status transaction mid-cycle
    always @(negedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_status(m_axis_tdata[STATUS_W-1:0]);
    end

    // call at a rising edge; returns at the edge where the transaction happened, or after the gap that ends a burst
    task automatic send_request(input logic [FUNC_W-1:0] func, input logic [KEY_W-1:0] key);
        bit taken;
        int gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'b0, key, func};
        do
        begin
            @(negedge clk);
            taken = s_axis_tready;
            @(posedge clk);
        end
        while (!taken);
        sb.note_request(func, key);
        burst_left--;
        if (burst_left <= 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = $urandom_range(0, 6);
            if (gap > 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    task automatic wait_for_results();
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    // mostly a small pool so buckets fill up, plus keys near the top and wide random ones
    function automatic logic [KEY_W-1:0] pick_key();
        int unsigned r;
        logic [KEY_W-1:0] k;
        r = $urandom_range(0, 99);
        if (r < 70)
            k = KEY_W'(10 * $urandom_range(0, 11) + $urandom_range(0, 9));
        else if (r < 80)
            k = KEY_MAX - KEY_W'($urandom_range(0, 29));
        else
            k = KEY_W'($urandom());
        return k;
    endfunction

    function automatic logic [FUNC_W-1:0] pick_func();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 40)
            return FUNC_INSERT;
        else if (r < 65)
            return FUNC_FIND;
        else if (r < 95)
            return FUNC_DELETE;
        else
            return FUNC_UNUSED;
    endfunction

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty set, duplicate and repeated delete on key zero; then the unused opcode and the largest key
        send_request(FUNC_FIND, '0);
        send_request(FUNC_INSERT, '0);
        send_request(FUNC_INSERT, '0);
        send_request(FUNC_FIND, '0);
        send_request(FUNC_DELETE, '0);
        send_request(FUNC_DELETE, '0);
        send_request(FUNC_UNUSED, KEY_MAX);
        send_request(FUNC_INSERT, KEY_MAX);
        send_request(FUNC_FIND, KEY_MAX);
        send_request(FUNC_DELETE, KEY_MAX);
        // fill bucket 7, overflow it, then reuse a freed middle slot
        for (int j = 0; j < BUCKET_SLOTS; j++)
            send_request(FUNC_INSERT, 31'(7 + 10 * j));
        send_request(FUNC_INSERT, 31'(7 + 10 * BUCKET_SLOTS));
        send_request(FUNC_DELETE, 31'd37);
        send_request(FUNC_INSERT, 31'(7 + 10 * BUCKET_SLOTS));
        send_request(FUNC_FIND, 31'(7 + 10 * BUCKET_SLOTS));
        send_request(FUNC_FIND, 31'd37);

        for (int n = 0; n < RANDOM_REQS; n++)
        begin
            if (n == RANDOM_REQS / 2)
                wait_for_results();
            send_request(pick_func(), pick_key());
        end

        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.failures == 0 && sb.pending() == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule
